// File: sv/plpd_pkg.sv
// shared types, widths and arithmetic steps for the point-to-line projection block
`timescale 1ns / 1ps

package plpd_pkg;

  // coordinate and intermediate widths
  localparam int CW     = 24;            // coordinate width
  localparam int DW     = CW + 1;        // coordinate difference
  localparam int PW     = 2 * DW;        // product / squared length magnitude
  localparam int DOTW   = PW + 1;        // signed dot product
  localparam int HW     = DW;            // low slice of the dot magnitude
  localparam int NW     = PW + DW;       // dividend width
  localparam int QW     = DW;            // quotient bits, one per divider stage
  localparam int CQW    = QW + 1;        // signed projection component
  localparam int RW     = CQW + 1;       // foot sum and residual
  localparam int R2W    = 2 * RW + 1;    // squared residual length
  localparam int SQW    = (R2W + 1) / 2; // root bits, one per root stage
  localparam int SRW    = SQW + 2;       // root partial remainder
  localparam int QDEPTH = 4;             // request queue depth
  localparam int QAW    = 2;             // request queue pointer width

  // back pipeline: pop, multiply, sum, divider, foot/residual, square, sum, root, output
  localparam int BACK_ST = 3 + QW + 3 + SQW + 1;

  // request handed from front to back
  typedef struct packed {
    logic signed [DOTW-1:0] dot;
    logic [PW-1:0]          len2;
    logic signed [DW-1:0]   ax;
    logic signed [DW-1:0]   ay;
    logic signed [DW-1:0]   bx;
    logic signed [DW-1:0]   by;
    logic signed [CW-1:0]   sx;
    logic signed [CW-1:0]   sy;
    logic                   degen;
  } q_item_t;

  // queue status toward the neighbors
  typedef struct packed {
    logic valid;
    logic room;
  } q_stat_t;

  // side data riding along the divider
  typedef struct packed {
    logic [PW-1:0]        len2;
    logic                 negx;
    logic                 negy;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 degen;
  } side_t;

  // side data riding along the root unit
  typedef struct packed {
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
    logic                 degen;
  } late_t;

  // one restoring divider stage
  typedef struct packed {
    logic [PW-1:0] rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] q;
  } div_t;

  // one restoring square root stage
  typedef struct packed {
    logic [SRW-1:0]   rem;
    logic [SQW-1:0]   root;
    logic [2*SQW-1:0] op;
  } sq_t;

  // shift in one dividend bit, subtract the divisor when it fits
  function automatic div_t div_step(input div_t d, input logic [PW-1:0] den);
    logic [PW:0] sh;
    logic [PW:0] diff;
    logic        ge;
    div_t        r;
    sh    = {d.rem, d.nlo[QW-1]};
    diff  = sh - {1'b0, den};
    ge    = (sh >= {1'b0, den});
    r.rem = ge ? diff[PW-1:0] : sh[PW-1:0];
    r.nlo = d.nlo << 1;
    r.q   = {d.q[QW-2:0], ge};
    return r;
  endfunction

  // bring in two operand bits, settle one root bit
  function automatic sq_t sq_step(input sq_t s);
    logic [SRW+1:0] sh;
    logic [SRW+1:0] trial;
    logic           ge;
    sq_t            r;
    sh     = {s.rem, s.op[2*SQW-1 -: 2]};
    trial  = (SRW + 2)'({s.root, 2'b01});
    ge     = (sh >= trial);
    r.rem  = ge ? SRW'(sh - trial) : SRW'(sh);
    r.root = {s.root[SQW-2:0], ge};
    r.op   = s.op << 2;
    return r;
  endfunction

  // clamp a foot sum to the coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [RW-1:0] v);
    logic fits;
    fits = (v[RW-1:CW-1] == '0) || (v[RW-1:CW-1] == '1);
    if (fits) return v[CW-1:0];
    return v[RW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

endpackage

// File: sv/plpd_front.sv
// front part: takes requests, forms differences, products and the degenerate flag
`timescale 1ns / 1ps

module plpd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [plpd_pkg::CW-1:0] point_x,
  input  logic signed [plpd_pkg::CW-1:0] point_y,
  input  logic signed [plpd_pkg::CW-1:0] line_start_x,
  input  logic signed [plpd_pkg::CW-1:0] line_start_y,
  input  logic signed [plpd_pkg::CW-1:0] line_end_x,
  input  logic signed [plpd_pkg::CW-1:0] line_end_y,
  input  plpd_pkg::q_stat_t              qstat,
  output logic                          push,
  output plpd_pkg::q_item_t              push_item
);

  logic f1_v, f2_v, adv;

  // stage one: differences
  logic signed [plpd_pkg::DW-1:0] ax1, ay1, bx1, by1;
  logic signed [plpd_pkg::CW-1:0] sx1, sy1, sx2, sy2;
  logic signed [plpd_pkg::DW-1:0] ax2, ay2, bx2, by2;
  logic                           dg1, dg2;
  logic signed [plpd_pkg::DW-1:0] bx_next, by_next;

  // stage two: products
  logic signed [plpd_pkg::PW-1:0] pab_x, pab_y, pbb_x, pbb_y;

  // the two stages move together, held only by a full queue
  assign adv      = !f2_v || qstat.room;
  assign in_ready = adv;
  assign push     = f2_v && qstat.room;

  assign bx_next = plpd_pkg::DW'(line_end_x) - plpd_pkg::DW'(line_start_x);
  assign by_next = plpd_pkg::DW'(line_end_y) - plpd_pkg::DW'(line_start_y);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else if (adv) begin
      f1_v <= in_valid;
      f2_v <= f1_v;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ax1   <= plpd_pkg::DW'(point_x) - plpd_pkg::DW'(line_start_x);
      ay1   <= plpd_pkg::DW'(point_y) - plpd_pkg::DW'(line_start_y);
      bx1   <= bx_next;
      by1   <= by_next;
      sx1   <= line_start_x;
      sy1   <= line_start_y;
      dg1   <= (bx_next == '0) && (by_next == '0);
      pab_x <= ax1 * bx1;
      pab_y <= ay1 * by1;
      pbb_x <= bx1 * bx1;
      pbb_y <= by1 * by1;
      ax2   <= ax1;
      ay2   <= ay1;
      bx2   <= bx1;
      by2   <= by1;
      sx2   <= sx1;
      sy2   <= sy1;
      dg2   <= dg1;
    end
  end

  // dot product and squared length into the queue
  always_comb begin
    push_item.dot   = plpd_pkg::DOTW'(pab_x) + plpd_pkg::DOTW'(pab_y);
    push_item.len2  = pbb_x[plpd_pkg::PW-1:0] + pbb_y[plpd_pkg::PW-1:0];
    push_item.ax    = ax2;
    push_item.ay    = ay2;
    push_item.bx    = bx2;
    push_item.by    = by2;
    push_item.sx    = sx2;
    push_item.sy    = sy2;
    push_item.degen = dg2;
  end

endmodule

// File: sv/plpd_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps

module plpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  plpd_pkg::q_item_t   push_item,
  input  logic                pop,
  output plpd_pkg::q_item_t   pop_item,
  output plpd_pkg::q_stat_t   qstat
);

  plpd_pkg::q_item_t          mem [plpd_pkg::QDEPTH];
  logic [plpd_pkg::QAW-1:0]   wr, rd;
  logic [plpd_pkg::QAW:0]     cnt;

  assign qstat.valid = (cnt != '0);
  assign qstat.room  = (cnt != (plpd_pkg::QAW + 1)'(plpd_pkg::QDEPTH));
  assign pop_item    = mem[rd];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop)  rd <= rd + 1'b1;
      cnt <= cnt + (plpd_pkg::QAW + 1)'(push) - (plpd_pkg::QAW + 1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr] <= push_item;
  end

endmodule

// File: sv/plpd_back.sv
// back part: projection divide, foot point, residual and its square root
`timescale 1ns / 1ps

module plpd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  plpd_pkg::q_stat_t                qstat,
  input  plpd_pkg::q_item_t                pop_item,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [plpd_pkg::CW-1:0]   foot_x,
  output logic signed [plpd_pkg::CW-1:0]   foot_y,
  output logic [plpd_pkg::CW-1:0]          distance,
  output logic                            degenerate
);

  localparam int LAST = plpd_pkg::BACK_ST - 1;

  logic [plpd_pkg::BACK_ST-1:0] vld;
  logic                         adv;

  // side data along the divider (pop, multiply, sum, then one per divider stage)
  plpd_pkg::side_t sd [plpd_pkg::QW + 3];
  // side data along the root unit (foot/residual, square, sum, then one per root stage)
  plpd_pkg::late_t lt [plpd_pkg::SQW + 3];

  logic [plpd_pkg::PW-1:0]   dm;
  logic [plpd_pkg::DW-1:0]   bxm, bym;
  logic [plpd_pkg::PW-1:0]   plx, phx, ply, phy;
  logic [plpd_pkg::NW-1:0]   nx, ny;
  plpd_pkg::div_t            dvx [plpd_pkg::QW];
  plpd_pkg::div_t            dvy [plpd_pkg::QW];
  plpd_pkg::div_t            dx0, dy0;
  logic [plpd_pkg::RW-1:0]   rxm, rym;
  logic [2*plpd_pkg::RW-1:0] sqx, sqy;
  logic [plpd_pkg::R2W-1:0]  r2;
  plpd_pkg::sq_t             sqs [plpd_pkg::SQW];
  plpd_pkg::sq_t             sq0;

  logic signed [plpd_pkg::CQW-1:0] cx, cy;
  logic signed [plpd_pkg::RW-1:0]  fsx, fsy, rsx, rsy;
  logic [plpd_pkg::SQW-1:0]        root;

  // whole back pipeline holds while a result waits
  assign adv       = !vld[LAST] || out_ready;
  assign pop       = adv && qstat.valid;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAST-1:0], qstat.valid};
  end

  // pop: magnitudes and signs
  always_ff @(posedge clk) begin
    if (adv) begin
      dm  <= pop_item.dot[plpd_pkg::DOTW-1] ? plpd_pkg::PW'(-pop_item.dot)
                                            : plpd_pkg::PW'(pop_item.dot);
      bxm <= pop_item.bx[plpd_pkg::DW-1] ? plpd_pkg::DW'(-pop_item.bx)
                                         : plpd_pkg::DW'(pop_item.bx);
      bym <= pop_item.by[plpd_pkg::DW-1] ? plpd_pkg::DW'(-pop_item.by)
                                         : plpd_pkg::DW'(pop_item.by);
      sd[0].len2  <= pop_item.len2;
      sd[0].negx  <= pop_item.dot[plpd_pkg::DOTW-1] ^ pop_item.bx[plpd_pkg::DW-1];
      sd[0].negy  <= pop_item.dot[plpd_pkg::DOTW-1] ^ pop_item.by[plpd_pkg::DW-1];
      sd[0].ax    <= pop_item.ax;
      sd[0].ay    <= pop_item.ay;
      sd[0].sx    <= pop_item.sx;
      sd[0].sy    <= pop_item.sy;
      sd[0].degen <= pop_item.degen;
    end
  end

  // partial products of |dot| * |b|
  always_ff @(posedge clk) begin
    if (adv) begin
      plx   <= dm[plpd_pkg::HW-1:0] * bxm;
      phx   <= dm[plpd_pkg::PW-1:plpd_pkg::HW] * bxm;
      ply   <= dm[plpd_pkg::HW-1:0] * bym;
      phy   <= dm[plpd_pkg::PW-1:plpd_pkg::HW] * bym;
      sd[1] <= sd[0];
    end
  end

  // dividends
  always_ff @(posedge clk) begin
    if (adv) begin
      nx    <= plpd_pkg::NW'(plx) + (plpd_pkg::NW'(phx) << plpd_pkg::HW);
      ny    <= plpd_pkg::NW'(ply) + (plpd_pkg::NW'(phy) << plpd_pkg::HW);
      sd[2] <= sd[1];
    end
  end

  // divider input: the quotient stays below 2^QW, so the top bits start the remainder
  always_comb begin
    dx0.rem = nx[plpd_pkg::NW-1:plpd_pkg::QW];
    dx0.nlo = nx[plpd_pkg::QW-1:0];
    dx0.q   = '0;
    dy0.rem = ny[plpd_pkg::NW-1:plpd_pkg::QW];
    dy0.nlo = ny[plpd_pkg::QW-1:0];
    dy0.q   = '0;
  end

  // divider: one quotient bit per stage, x and y side by side
  for (genvar k = 0; k < plpd_pkg::QW; k++) begin : g_div
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          dvx[k]  <= plpd_pkg::div_step(dx0, sd[2].len2);
          dvy[k]  <= plpd_pkg::div_step(dy0, sd[2].len2);
          sd[k+3] <= sd[k+2];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          dvx[k]  <= plpd_pkg::div_step(dvx[k-1], sd[k+2].len2);
          dvy[k]  <= plpd_pkg::div_step(dvy[k-1], sd[k+2].len2);
          sd[k+3] <= sd[k+2];
        end
      end
    end
  end

  // signed projection, foot sum and residual
  always_comb begin
    cx  = sd[plpd_pkg::QW+2].negx ? -plpd_pkg::CQW'(dvx[plpd_pkg::QW-1].q)
                                  :  plpd_pkg::CQW'(dvx[plpd_pkg::QW-1].q);
    cy  = sd[plpd_pkg::QW+2].negy ? -plpd_pkg::CQW'(dvy[plpd_pkg::QW-1].q)
                                  :  plpd_pkg::CQW'(dvy[plpd_pkg::QW-1].q);
    fsx = plpd_pkg::RW'(sd[plpd_pkg::QW+2].sx) + plpd_pkg::RW'(cx);
    fsy = plpd_pkg::RW'(sd[plpd_pkg::QW+2].sy) + plpd_pkg::RW'(cy);
    rsx = plpd_pkg::RW'(sd[plpd_pkg::QW+2].ax) - plpd_pkg::RW'(cx);
    rsy = plpd_pkg::RW'(sd[plpd_pkg::QW+2].ay) - plpd_pkg::RW'(cy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lt[0].foot_x <= plpd_pkg::sat_coord(fsx);
      lt[0].foot_y <= plpd_pkg::sat_coord(fsy);
      lt[0].degen  <= sd[plpd_pkg::QW+2].degen;
      rxm          <= rsx[plpd_pkg::RW-1] ? plpd_pkg::RW'(-rsx) : plpd_pkg::RW'(rsx);
      rym          <= rsy[plpd_pkg::RW-1] ? plpd_pkg::RW'(-rsy) : plpd_pkg::RW'(rsy);
    end
  end

  // squares, then squared residual length
  always_ff @(posedge clk) begin
    if (adv) begin
      sqx   <= rxm * rxm;
      sqy   <= rym * rym;
      lt[1] <= lt[0];
      r2    <= plpd_pkg::R2W'(sqx) + plpd_pkg::R2W'(sqy);
      lt[2] <= lt[1];
    end
  end

  always_comb begin
    sq0.rem  = '0;
    sq0.root = '0;
    sq0.op   = (2 * plpd_pkg::SQW)'(r2);
  end

  // square root: one root bit per stage
  for (genvar k = 0; k < plpd_pkg::SQW; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          sqs[k]  <= plpd_pkg::sq_step(sq0);
          lt[k+3] <= lt[k+2];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          sqs[k]  <= plpd_pkg::sq_step(sqs[k-1]);
          lt[k+3] <= lt[k+2];
        end
      end
    end
  end

  assign root = sqs[plpd_pkg::SQW-1].root;

  // output register with saturation and the degenerate case
  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= lt[plpd_pkg::SQW+2].degen;
      if (lt[plpd_pkg::SQW+2].degen) begin
        foot_x   <= '0;
        foot_y   <= '0;
        distance <= '0;
      end else begin
        foot_x   <= lt[plpd_pkg::SQW+2].foot_x;
        foot_y   <= lt[plpd_pkg::SQW+2].foot_y;
        distance <= (root[plpd_pkg::SQW-1:plpd_pkg::CW] != '0) ? '1
                                                               : root[plpd_pkg::CW-1:0];
      end
    end
  end

endmodule

// File: sv/point_line_projection_distance.sv
// top level: point to line foot point and perpendicular distance
// throughput: one request per cycle unless the output stalls, set by the fully
// pipelined divider and root unit
// a four-entry queue between front and back lets each side stall on its own
// reset: synchronous, clears all valid bits and the queue; no payload is cleared
`timescale 1ns / 1ps

module point_line_projection_distance (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [plpd_pkg::CW-1:0]   point_x,
  input  logic signed [plpd_pkg::CW-1:0]   point_y,
  input  logic signed [plpd_pkg::CW-1:0]   line_start_x,
  input  logic signed [plpd_pkg::CW-1:0]   line_start_y,
  input  logic signed [plpd_pkg::CW-1:0]   line_end_x,
  input  logic signed [plpd_pkg::CW-1:0]   line_end_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [plpd_pkg::CW-1:0]   foot_x,
  output logic signed [plpd_pkg::CW-1:0]   foot_y,
  output logic [plpd_pkg::CW-1:0]          distance,
  output logic                            degenerate
);

  plpd_pkg::q_stat_t qstat;
  plpd_pkg::q_item_t push_item, pop_item;
  logic              push, pop;

  // front
  plpd_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .point_x, .point_y, .line_start_x, .line_start_y, .line_end_x, .line_end_y,
    .qstat, .push, .push_item
  );

  // queue
  plpd_queue u_queue (
    .clk, .rst, .push, .push_item, .pop, .pop_item, .qstat
  );

  // back
  plpd_back u_back (
    .clk, .rst, .qstat, .pop_item, .pop,
    .out_valid, .out_ready, .foot_x, .foot_y, .distance, .degenerate
  );

  // checks
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> foot_x == '0 && foot_y == '0 && distance == '0)
    else $error("degenerate result with nonzero fields");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> qstat.room)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("pop from an empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !qstat.valid)
    else $error("results or requests present after reset");

endmodule

// File: verif/point_line_projection_distance_test.sv
// self-checking testbench for the point-to-line foot point and distance block
`timescale 1ns / 1ps

module point_line_projection_distance_test;

  localparam int CW = plpd_pkg::CW;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    logic signed [CW-1:0] px, py, sx, sy, ex, ey;
  } query_t;

  typedef struct {
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
    logic [CW-1:0]        distance;
    logic                 degenerate;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] point_x = '0, point_y = '0;
  logic signed [CW-1:0] line_start_x = '0, line_start_y = '0;
  logic signed [CW-1:0] line_end_x = '0, line_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] foot_x, foot_y;
  logic [CW-1:0] distance;
  logic degenerate;

  query_t pending_queries[$];
  proj_t  expected_projs[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;
  int     errors = 0;
  int     accepted = 0;
  int     checked = 0;
  int     degen_seen = 0;

  point_line_projection_distance dut (.*);

  always #5 clk = ~clk;

  // exact projection of one query
  function automatic proj_t project(input query_t q);
    logic signed [127:0] ax, ay, bx, by, dot, len2, cx, cy, rx, ry, fx, fy;
    logic [127:0] r2, root, cand;
    proj_t r;
    ax = $signed(q.px) - $signed(q.sx);
    ay = $signed(q.py) - $signed(q.sy);
    bx = $signed(q.ex) - $signed(q.sx);
    by = $signed(q.ey) - $signed(q.sy);
    if (bx == 0 && by == 0) begin
      r.foot_x = '0; r.foot_y = '0; r.distance = '0; r.degenerate = 1'b1;
      return r;
    end
    dot  = ax * bx + ay * by;
    len2 = bx * bx + by * by;
    // signed division truncates toward zero
    cx = (dot * bx) / len2;
    cy = (dot * by) / len2;
    rx = ax - cx;
    ry = ay - cy;
    r2 = rx * rx + ry * ry;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= r2) root = cand;
    end
    fx = $signed(q.sx) + cx;
    fy = $signed(q.sy) + cy;
    r.foot_x = (fx > $signed(CMAX)) ? CMAX : (fx < $signed(CMIN)) ? CMIN : fx[CW-1:0];
    r.foot_y = (fy > $signed(CMAX)) ? CMAX : (fy < $signed(CMIN)) ? CMIN : fy[CW-1:0];
    r.distance = (root > 128'hFFFFFF) ? {CW{1'b1}} : root[CW-1:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  // random coordinate: full range, small, or an extreme
  function automatic logic signed [CW-1:0] rand_coord();
    int m;
    m = $urandom_range(9);
    if (m < 5) return CW'($urandom);
    if (m < 8) return CW'($signed($urandom_range(4000)) - 2000);
    return $urandom_range(1) ? CMAX : CMIN;
  endfunction

  task automatic add_query(input logic signed [CW-1:0] px, py, sx, sy, ex, ey);
    query_t q;
    q.px = px; q.py = py; q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey;
    pending_queries.push_back(q);
  endtask

  task automatic add_random(input int n);
    query_t q;
    for (int i = 0; i < n; i++) begin
      q.px = rand_coord(); q.py = rand_coord();
      q.sx = rand_coord(); q.sy = rand_coord();
      // occasional coincident or nearly coincident line points
      if ($urandom_range(19) == 0) begin
        q.ex = q.sx; q.ey = q.sy;
      end else if ($urandom_range(9) == 0) begin
        q.ex = q.sx + CW'($signed($urandom_range(2)) - 1);
        q.ey = q.sy + CW'($signed($urandom_range(2)) - 1);
      end else begin
        q.ex = rand_coord(); q.ey = rand_coord();
      end
      pending_queries.push_back(q);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        query_t q;
        q.px = point_x; q.py = point_y; q.sx = line_start_x; q.sy = line_start_y;
        q.ex = line_end_x; q.ey = line_end_y;
        expected_projs.push_back(project(q));
        accepted++;
      end
      if (pending_queries.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        query_t n;
        n = pending_queries.pop_front();
        point_x <= n.px; point_y <= n.py;
        line_start_x <= n.sx; line_start_y <= n.sy;
        line_end_x <= n.ex; line_end_y <= n.ey;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold-off on demand
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      hold_cnt <= (hold_cnt == 1) ? -1 : hold_cnt;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_projs.size() == 0) begin
        $error("unexpected result foot_x=%0d foot_y=%0d", foot_x, foot_y);
        errors++;
      end else begin
        proj_t e;
        e = expected_projs.pop_front();
        checked++;
        if (e.degenerate) degen_seen++;
        if (foot_x !== e.foot_x) begin
          $error("foot_x expected %0d actual %0d", e.foot_x, foot_x); errors++;
        end
        if (foot_y !== e.foot_y) begin
          $error("foot_y expected %0d actual %0d", e.foot_y, foot_y); errors++;
        end
        if (distance !== e.distance) begin
          $error("distance expected %0d actual %0d", e.distance, distance); errors++;
        end
        if (degenerate !== e.degenerate) begin
          $error("degenerate expected %0d actual %0d", e.degenerate, degenerate); errors++;
        end
      end
    end
  end

  task automatic drain();
    wait (pending_queries.size() == 0 && !in_valid);
    wait (expected_projs.size() == 0);
  endtask

  // stimulus phases
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    add_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    add_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    add_query(CMAX, CMIN, 24'sd100, 24'sd100, 24'sd100, 24'sd100);
    add_query(CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
    add_query(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
    add_query(CMAX, 24'sd0, CMIN, CMIN, CMIN, CMAX);
    add_query(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN);
    add_query(CMIN, CMIN, CMAX, 24'sd0, CMAX - 1, CMAX);
    add_query(CMAX, CMAX, CMIN, 24'sd0, CMIN + 1, CMIN);
    add_query(24'sd256, 24'sd512, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
    add_query(24'sd256, 24'sd512, 24'sd0, 24'sd0, 24'sd0, 24'sd256);
    add_query(-24'sd300, 24'sd77, 24'sd0, 24'sd0, 24'sd1, 24'sd1);
    add_query(24'sd5, -24'sd3, 24'sd0, 24'sd0, -24'sd1, 24'sd0);
    add_query(24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd1);
    add_query(CMAX, CMAX, CMIN, CMAX, CMIN + 1, CMIN);
    add_query(CMIN, CMAX, CMAX, CMIN, CMAX, CMIN + 1);
    add_query(24'sd1000, 24'sd1000, 24'sd0, 24'sd0, CMAX, 24'sd1);
    add_query(-24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'sd2, 24'sd3);
    drain();

    // no idling, with a long receiver hold-off
    send_idle_pct = 0; recv_stall_pct = 0;
    add_random(280);
    repeat (20) @(posedge clk);
    hold_req = 1'b1;
    wait (hold_cnt > 0);
    hold_req = 1'b0;
    drain();

    send_idle_pct = 75; recv_stall_pct = 0;
    add_random(270);
    drain();

    send_idle_pct = 0; recv_stall_pct = 75;
    add_random(270);
    drain();

    send_idle_pct = 14; recv_stall_pct = 14;
    add_random(270);
    drain();

    repeat (100) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d degenerate lines",
             accepted, checked, degen_seen);
    $display("phases: no idling with long hold-off, sender idle, receiver stall, both");
    if (errors == 0 && expected_projs.size() == 0) begin
      $display("[point_line_projection_distance] OK");
    end else begin
      $display("[point_line_projection_distance] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[point_line_projection_distance] ERROR");
    $finish;
  end

endmodule

// File: files.f
sv/plpd_pkg.sv
sv/plpd_front.sv
sv/plpd_queue.sv
sv/plpd_back.sv
sv/point_line_projection_distance.sv
verif/point_line_projection_distance_test.sv
